// ===== rtl/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg
// Types and character constants shared by the ASCII integer parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGNED = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    WIDTH_16 = 2'd0,
    WIDTH_32 = 2'd1,
    WIDTH_64 = 2'd2,
    WIDTH_XX = 2'd3
  } width_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_MODE   = 2'd0,
    CFG_SIGNED_MODE = 2'd1,
    CFG_WIDTH_SEL   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    base_e  base_mode;
    logic   signed_mode;
    width_e width_sel;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [ValueW-1:0] acc;
    logic              neg;
    base_e             base;
  } state_t;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    logic [CharW-1:0]  end_char;
    logic              status;
  } result_t;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_SEVEN = 8'h37;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_F  = 8'h46;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_LO_X  = 8'h78;
  localparam logic [CharW-1:0] CH_UP_X  = 8'h58;

  localparam state_t StateIdle = '{
    phase: PH_IDLE, acc: '0, neg: 1'b0, base: BASE_DEC
  };

endpackage

`default_nettype wire

// ===== rtl/aip_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aip_cfg_regs
// Configuration registers: base mode, signed mode and result width.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aip_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [aip_pkg::CfgDataW-1:0]  cfg_data_i,
  output aip_pkg::cfg_t                      cfg_o
);
  import aip_pkg::*;

  cfg_t cfg_q, cfg_d;
  cfg_idx_e idx;

  assign cfg_ready_o = 1'b1;
  assign idx = cfg_idx_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (idx)
        CFG_BASE_MODE:   cfg_d.base_mode   = base_e'(cfg_data_i);
        CFG_SIGNED_MODE: cfg_d.signed_mode = cfg_data_i[0];
        CFG_WIDTH_SEL:   cfg_d.width_sel   = width_e'(cfg_data_i);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_mode: BASE_DEC, signed_mode: 1'b1, width_sel: WIDTH_32};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/aip_step.sv =====
// ----------------------------------------------------------------------------
// aip_step
// One parse step: next parser state and the result word for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_step (
  input  aip_pkg::state_t                   state_i,
  input  aip_pkg::cfg_t                     cfg_i,
  input  wire logic [aip_pkg::CharW-1:0]    ch_i,
  output aip_pkg::state_t                   state_o,
  output aip_pkg::result_t                  res_o
);
  import aip_pkg::*;

  logic              is_space, is_num, is_up, is_lo, is_oct;
  logic [3:0]        dval;
  logic              idle;
  base_e             base0, base_eff;
  logic [ValueW-1:0] acc_cur, mask, acc_mul, acc_new, val_emit;
  logic              neg_cur, digit_ok, zero_prefix;

  assign is_space = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
  assign is_num   = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_oct   = (ch_i >= CH_ZERO) && (ch_i <= CH_SEVEN);
  assign is_up    = (ch_i >= CH_UP_A) && (ch_i <= CH_UP_F);
  assign is_lo    = (ch_i >= CH_LO_A) && (ch_i <= CH_LO_F);

  always_comb begin
    priority if (is_num) begin
      dval = 4'(ch_i - CH_ZERO);
    end else if (is_up) begin
      dval = 4'(ch_i - CH_UP_A) + 4'd10;
    end else begin
      dval = 4'(ch_i - CH_LO_A) + 4'd10;
    end
  end

  always_comb begin
    unique case (cfg_i.width_sel)
      WIDTH_16: mask = {{(ValueW-16){1'b0}}, {16{1'b1}}};
      WIDTH_32: mask = {{(ValueW-32){1'b0}}, {32{1'b1}}};
      default:  mask = {ValueW{1'b1}};
    endcase
  end

  assign idle     = (state_i.phase == PH_IDLE);
  assign acc_cur  = idle ? '0 : state_i.acc;
  assign neg_cur  = idle ? 1'b0 : state_i.neg;
  assign base0    = idle ? cfg_i.base_mode : state_i.base;
  assign base_eff = (base0 == BASE_AUTO) ? BASE_DEC : base0;

  always_comb begin
    unique case (base_eff)
      BASE_OCT: begin
        digit_ok = is_oct;
        acc_mul  = acc_cur << 3;
      end
      BASE_HEX: begin
        digit_ok = is_num || is_up || is_lo;
        acc_mul  = acc_cur << 4;
      end
      default: begin
        digit_ok = is_num;
        acc_mul  = (acc_cur << 3) + (acc_cur << 1);
      end
    endcase
  end

  assign acc_new  = (acc_mul + {{(ValueW-4){1'b0}}, dval}) & mask;
  assign val_emit = ((cfg_i.signed_mode && neg_cur) ? (64'd0 - acc_cur) : acc_cur) & mask;

  // leading zero may open a prefix only straight after start or sign
  assign zero_prefix = (ch_i == CH_ZERO) && ((base0 == BASE_AUTO) || (base0 == BASE_HEX));

  always_comb begin
    state_o        = state_i;
    res_o.emit     = 1'b0;
    res_o.value    = val_emit;
    res_o.end_char = ch_i;
    res_o.status   = 1'b0;
    unique case (state_i.phase)
      PH_IDLE, PH_SIGNED: begin
        priority if (idle && is_space) begin
          state_o = state_i;
        end else if (idle && (ch_i == CH_NUL)) begin
          state_o      = StateIdle;
          res_o.emit   = 1'b1;
          res_o.value  = '0;
          res_o.status = 1'b1;
        end else if (idle && ((ch_i == CH_MINUS) || (ch_i == CH_PLUS))) begin
          state_o.phase = PH_SIGNED;
          state_o.acc   = '0;
          state_o.neg   = (ch_i == CH_MINUS);
          state_o.base  = cfg_i.base_mode;
        end else if (zero_prefix) begin
          state_o.phase = PH_ZERO;
          state_o.acc   = acc_cur;
          state_o.neg   = neg_cur;
          state_o.base  = (base0 == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        end else if (digit_ok) begin
          state_o.phase = PH_DIGITS;
          state_o.acc   = acc_new;
          state_o.neg   = neg_cur;
          state_o.base  = base_eff;
        end else begin
          state_o    = StateIdle;
          res_o.emit = 1'b1;
        end
      end
      PH_ZERO: begin
        priority if ((ch_i == CH_LO_X) || (ch_i == CH_UP_X)) begin
          state_o.phase = PH_DIGITS;
          state_o.base  = BASE_HEX;
        end else if (digit_ok) begin
          state_o.phase = PH_DIGITS;
          state_o.acc   = acc_new;
        end else begin
          state_o    = StateIdle;
          res_o.emit = 1'b1;
        end
      end
      default: begin
        if (digit_ok) begin
          state_o.acc = acc_new;
        end else begin
          state_o    = StateIdle;
          res_o.emit = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ascii_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Converts integer text, one ASCII character per word, into a binary value.
//
// Input channel (in_valid_i/in_ready_o, ch_i) takes one character per word.
// White space is skipped, an optional sign is taken, then digits of the base
// (auto, octal, decimal or hexadecimal, with 0 / 0x prefixes) are summed,
// wrapping at 16, 32 or 64 bits. The first non-digit ends the number and
// produces one result word (value_o, end_char_o, status_o) on the output
// channel; a NUL before any sign or digit gives status 1.
// Configuration port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i):
// index 0 base mode, 1 signed mode, 2 width select; other indexes ignored.
// Write it only while no character is in flight.
// The terminating character is held in the input register and its result is
// then loaded into the result register. Throughput: one character per cycle
// unless the receiver stalls; the accumulator multiply-add is combinational.
// Reset clears the parser to idle with decimal base, signed mode on and a
// 32-bit width. A stalled receiver holds the result register; the input
// register then fills and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aip_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [aip_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [aip_pkg::CharW-1:0]     ch_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [aip_pkg::ValueW-1:0]         value_o,
  output logic [aip_pkg::CharW-1:0]          end_char_o,
  output logic                               status_o
);
  import aip_pkg::*;

  cfg_t              cfg;
  state_t            state_q, state_d;
  result_t           res;
  logic              in_valid_q;
  logic [CharW-1:0]  ch_q;
  logic              out_valid_q;
  logic [ValueW-1:0] value_q;
  logic [CharW-1:0]  end_char_q;
  logic              status_q;
  logic              advance;

  aip_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aip_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .ch_i    (ch_q),
    .state_o (state_d),
    .res_o   (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= ch_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      value_q    <= res.value;
      end_char_q <= res.end_char;
      status_q   <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign end_char_o  = end_char_q;
  assign status_o    = status_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> state_q.acc == '0 && !state_q.neg)
    else $error("idle parser holds a stale accumulator or sign");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.emit |=> state_q.phase == PH_IDLE)
    else $error("parser not idle after a result");

  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> value_o == '0 && end_char_o == CH_NUL)
    else $error("end of text result carries data");

  a_width16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.emit && cfg.width_sel == WIDTH_16 |=> value_o[ValueW-1:16] == '0)
    else $error("16-bit result not zero extended");

endmodule

`default_nettype wire
